FILE: hdl/load_based_clock_level_governor_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the load based clock level governor
// Each check is sampled on the rising edge of clk and is off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef LOAD_BASED_CLOCK_LEVEL_GOVERNOR_TOP_ASSERT_SVH
`define LOAD_BASED_CLOCK_LEVEL_GOVERNOR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// The expression holds at every clock edge.
`define LBCLG_ASSERT_HOLDS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("governor check failed");
// When the antecedent holds, the consequent holds in the next cycle.
`define LBCLG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("governor sequence check failed");
`else
`define LBCLG_ASSERT_HOLDS(lbl, expr)
`define LBCLG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/lbclg_pkg.sv
// ---------------------------------------------------------------------------
// lbclg_pkg
// Shared types, codes and level tables of the clock level governor.
// ---------------------------------------------------------------------------
package lbclg_pkg;

  localparam int LOAD_W      = 7;
  localparam int DIV_CNT_W   = $clog2(LOAD_W);
  localparam int NUM_LEVELS  = 9;
  localparam int TALLY_FULL  = 10;

  typedef logic [LOAD_W-1:0] load_t;
  typedef logic [3:0]        level_t;

  typedef enum logic [3:0] {
    OP_TICK   = 4'd0,
    OP_IDLE   = 4'd1,
    OP_BUSY   = 4'd2,
    OP_POLL   = 4'd3,
    OP_MANUAL = 4'd4,
    OP_AUTO   = 4'd5,
    OP_FIXED  = 4'd6,
    OP_ADJUST = 4'd7,
    OP_TALLY  = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_FAST  = 2'd1,
    ST_BAD_LEVEL = 2'd2,
    ST_CONFLICT  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_CHECK_INTERVAL = 3'd0,
    REG_LOAD_HIGH      = 3'd1,
    REG_LOAD_LOW       = 3'd2,
    REG_INTERVAL_UP    = 3'd3,
    REG_INTERVAL_DOWN  = 3'd4,
    REG_JUMP_UP        = 3'd5,
    REG_STEP_DOWN      = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_DIV_WAIT,
    FSM_DECIDE,
    FSM_RESULT
  } fsm_t;

  // Result of the load divider as seen by the controller.
  typedef struct packed {
    logic  done;
    load_t quot;
  } div_rsp_t;

  typedef struct packed {
    logic [6:0] freq_mhz;
    logic       use_pll;
    logic [3:0] pll_mult;
    logic [1:0] flash_wait;
  } level_info_t;

  // Clock settings of one level: 8 MHz apart, PLL for all but the slowest.
  function automatic level_info_t level_info(input level_t lv);
    level_info_t info;
    info.freq_mhz = 7'd72 - {lv, 3'b000};
    info.use_pll  = (lv < 4'd8);
    info.pll_mult = info.use_pll ? (4'd9 - lv) : 4'd0;
    if (lv <= 4'd2) begin
      info.flash_wait = 2'd2;
    end else if (lv <= 4'd5) begin
      info.flash_wait = 2'd1;
    end else begin
      info.flash_wait = 2'd0;
    end
    return info;
  endfunction

  // Load from a one-second idle tally below ten: 100 - 10 * n.
  function automatic load_t tally_load(input logic [3:0] n);
    logic [6:0] tens;
    tens = {n, 3'b000} + {2'b00, n, 1'b0};
    return 7'd100 - tens;
  endfunction

endpackage

FILE: hdl/load_based_clock_level_governor_top.sv
// ---------------------------------------------------------------------------
// load_based_clock_level_governor_top
// Sequence: every event passes the idle, execute and result states. An
//   evaluating poll also passes the decide state and, when marks were
//   counted, the divider wait state for the seven quotient bits.
// A new event is taken only once the result of the last one is stored.
// Reset (rst_n low, synchronous): manual mode, level 0, counters and timers
//   cleared, configuration registers back to their default values.
// ---------------------------------------------------------------------------
`include "load_based_clock_level_governor_top_assert.svh"

// The governor keeps a millisecond time base, idle and busy counters and the
// current clock level. Every accepted event produces exactly one result that
// reports the level, its clock settings, the last load figure and the mode.
//
// The controller works on one event at a time: it takes the event in the idle
// state, updates the state in the execute state and loads the result register
// in the result state. A poll that is due hands busy*100/(idle+busy) to the
// divider if marks were counted, which produces one quotient bit per cycle,
// and then decides on a raise or a lowering of the clock. The output register
// lets the next event be taken while an earlier result waits for its transfer.
module load_based_clock_level_governor_top #(
  parameter int COUNT_WIDTH = 16,
  parameter int TICK_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input events. in_tdata from bit 0: op[3:0], level_arg[11:4], step[19:12].
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  // Results. out_tdata from bit 0: status[1:0], level[5:2], freq_mhz[12:6],
  // use_pll[13], pll_multiplier[17:14], flash_wait[19:18], busy_pct[26:20],
  // auto_mode[27], level_changed[28], zero fill above.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import lbclg_pkg::*;

  // Configuration registers.
  logic [15:0] chk_int_r;
  logic [6:0]  load_hi_r;
  logic [6:0]  load_lo_r;
  logic [15:0] int_up_r;
  logic [15:0] int_dn_r;
  logic [3:0]  jump_up_r;
  logic [3:0]  step_dn_r;

  // Controller and governor state.
  fsm_t                   state_r, state_nxt;
  op_t                    op_r;
  logic [7:0]             arg_r;
  logic [7:0]             step_r;
  level_t                 before_r;
  level_t                 level_r, level_nxt;
  logic                   auto_r, auto_nxt;
  level_t                 floor_r, floor_nxt;
  logic [TICK_WIDTH-1:0]  now_r, now_nxt;
  logic [TICK_WIDTH-1:0]  last_sw_r, last_sw_nxt;
  logic [TICK_WIDTH-1:0]  last_chk_r, last_chk_nxt;
  logic [COUNT_WIDTH-1:0] idle_r, idle_nxt;
  logic [COUNT_WIDTH-1:0] busy_r, busy_nxt;
  logic [COUNT_WIDTH-1:0] sec_idle_r, sec_idle_nxt;
  load_t                  load_r, load_nxt;
  status_t                status_r, status_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [31:0]            out_data_r, out_data_nxt;

  // Derived values.
  logic [COUNT_WIDTH:0]   total_cnt;
  logic [TICK_WIDTH-1:0]  since_chk;
  logic [TICK_WIDTH-1:0]  since_sw;
  logic                   poll_due;
  logic                   div_start;
  div_rsp_t               div_rsp;
  logic signed [8:0]      adj_sum;
  level_t                 adj_level;
  level_t                 up_level;
  logic [4:0]             dn_sum;
  level_t                 dn_level;
  level_t                 arg_level;
  logic                   arg_bad;
  logic                   cnt_max_idle;
  logic                   cnt_max_busy;
  logic                   cnt_max_sec;
  level_info_t            info;

  // Always taken: users must write configuration only while no event is open.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_int_r <= 16'd50;
      load_hi_r <= 7'd50;
      load_lo_r <= 7'd30;
      int_up_r  <= 16'd1000;
      int_dn_r  <= 16'd5000;
      jump_up_r <= 4'd3;
      step_dn_r <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CHECK_INTERVAL: chk_int_r <= cfg_data;
        REG_LOAD_HIGH:      load_hi_r <= cfg_data[6:0];
        REG_LOAD_LOW:       load_lo_r <= cfg_data[6:0];
        REG_INTERVAL_UP:    int_up_r  <= cfg_data;
        REG_INTERVAL_DOWN:  int_dn_r  <= cfg_data;
        REG_JUMP_UP:        jump_up_r <= cfg_data[3:0];
        REG_STEP_DOWN:      step_dn_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Elapsed times wrap with the tick counter.
  assign total_cnt = {1'b0, idle_r} + {1'b0, busy_r};
  assign since_chk = now_r - last_chk_r;
  assign since_sw  = now_r - last_sw_r;
  assign poll_due  = auto_r && (since_chk >= TICK_WIDTH'(chk_int_r));
  assign div_start = (state_r == FSM_EXEC) && (op_r == OP_POLL) && poll_due &&
                     (total_cnt != '0);

  assign cnt_max_idle = (idle_r == '1);
  assign cnt_max_busy = (busy_r == '1);
  assign cnt_max_sec  = (sec_idle_r == '1);

  // Manual adjust: level plus signed step, clamped to the level range.
  assign adj_sum = $signed({5'b0, level_r}) + $signed({step_r[7], step_r});
  always_comb begin
    if (adj_sum < 9'sd0) begin
      adj_level = 4'd0;
    end else if (adj_sum > 9'sd8) begin
      adj_level = 4'd8;
    end else begin
      adj_level = adj_sum[3:0];
    end
  end

  // Automatic moves: toward level 0 by jump_up, toward the floor by step_down.
  assign up_level  = (level_r > jump_up_r) ? (level_r - jump_up_r) : 4'd0;
  assign dn_sum    = {1'b0, level_r} + {1'b0, step_dn_r};
  assign dn_level  = (dn_sum > {1'b0, floor_r}) ? floor_r : dn_sum[3:0];

  assign arg_bad   = (arg_r >= 8'(NUM_LEVELS));
  assign arg_level = arg_r[3:0];

  lbclg_div #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .busy_cnt  (busy_r),
    .total_cnt (total_cnt),
    .rsp       (div_rsp)
  );

  assign info = level_info(level_r);

  always_comb begin
    state_nxt     = state_r;
    level_nxt     = level_r;
    auto_nxt      = auto_r;
    floor_nxt     = floor_r;
    now_nxt       = now_r;
    last_sw_nxt   = last_sw_r;
    last_chk_nxt  = last_chk_r;
    idle_nxt      = idle_r;
    busy_nxt      = busy_r;
    sec_idle_nxt  = sec_idle_r;
    load_nxt      = load_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // The downstream side drains the result register independently.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      FSM_IDLE: begin
        if (in_tvalid) begin
          state_nxt = FSM_EXEC;
        end
      end

      FSM_EXEC: begin
        status_nxt = ST_OK;
        state_nxt  = FSM_RESULT;
        unique case (op_r)
          OP_TICK: now_nxt = now_r + 1'b1;
          OP_IDLE: begin
            if (auto_r) begin
              if (!cnt_max_idle) idle_nxt = idle_r + 1'b1;
              if (!cnt_max_sec)  sec_idle_nxt = sec_idle_r + 1'b1;
            end
          end
          OP_BUSY: begin
            if (auto_r && !cnt_max_busy) begin
              busy_nxt = busy_r + 1'b1;
            end
          end
          OP_POLL: begin
            if (poll_due) begin
              last_chk_nxt = now_r;
              idle_nxt     = '0;
              busy_nxt     = '0;
              if (total_cnt == '0) begin
                load_nxt  = '0;
                state_nxt = FSM_DECIDE;
              end else begin
                state_nxt = FSM_DIV_WAIT;
              end
            end
          end
          OP_MANUAL: begin
            if ((now_r != '0) && (since_sw < TICK_WIDTH'(int_up_r))) begin
              status_nxt = ST_TOO_FAST;
            end else begin
              auto_nxt    = 1'b0;
              last_sw_nxt = now_r;
              if (arg_bad) begin
                status_nxt = ST_BAD_LEVEL;
              end else begin
                level_nxt = arg_level;
              end
            end
          end
          OP_AUTO: begin
            auto_nxt     = 1'b1;
            floor_nxt    = arg_bad ? 4'd8 : arg_level;
            idle_nxt     = '0;
            busy_nxt     = '0;
            load_nxt     = '0;
            last_chk_nxt = now_r;
          end
          OP_FIXED: begin
            if (auto_r) begin
              status_nxt = ST_CONFLICT;
            end else if (arg_bad) begin
              status_nxt = ST_BAD_LEVEL;
            end else begin
              level_nxt = arg_level;
            end
          end
          OP_ADJUST: begin
            if (auto_r) begin
              status_nxt = ST_CONFLICT;
            end else begin
              level_nxt = adj_level;
            end
          end
          OP_TALLY: begin
            if (auto_r) begin
              load_nxt = (sec_idle_r >= COUNT_WIDTH'(TALLY_FULL)) ? '0
                                                                   : tally_load(sec_idle_r[3:0]);
              sec_idle_nxt = '0;
            end
          end
          default: ;
        endcase
      end

      FSM_DIV_WAIT: begin
        if (div_rsp.done) begin
          load_nxt  = div_rsp.quot;
          state_nxt = FSM_DECIDE;
        end
      end

      FSM_DECIDE: begin
        // High load wins over low load; each waits for its own interval.
        if (load_r > load_hi_r) begin
          if ((since_sw >= TICK_WIDTH'(int_up_r)) && (level_r != 4'd0)) begin
            level_nxt   = up_level;
            last_sw_nxt = now_r;
          end
        end else if (load_r < load_lo_r) begin
          if ((since_sw >= TICK_WIDTH'(int_dn_r)) && (level_r < floor_r)) begin
            level_nxt   = dn_level;
            last_sw_nxt = now_r;
          end
        end
        state_nxt = FSM_RESULT;
      end

      FSM_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'b000, (level_r != before_r), auto_r, load_r,
                           info.flash_wait, info.pll_mult, info.use_pll,
                           info.freq_mhz, level_r, status_r};
          state_nxt     = FSM_IDLE;
        end
      end

      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      level_r     <= '0;
      auto_r      <= 1'b0;
      floor_r     <= '0;
      now_r       <= '0;
      last_sw_r   <= '0;
      last_chk_r  <= '0;
      idle_r      <= '0;
      busy_r      <= '0;
      sec_idle_r  <= '0;
      load_r      <= '0;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      auto_r      <= auto_nxt;
      floor_r     <= floor_nxt;
      now_r       <= now_nxt;
      last_sw_r   <= last_sw_nxt;
      last_chk_r  <= last_chk_nxt;
      idle_r      <= idle_nxt;
      busy_r      <= busy_nxt;
      sec_idle_r  <= sec_idle_nxt;
      load_r      <= load_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Event fields and the result word need no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r     <= op_t'(in_tdata[3:0]);
      arg_r    <= in_tdata[11:4];
      step_r   <= in_tdata[19:12];
      before_r <= level_r;
    end
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == FSM_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Level and floor stay within the nine levels; the load never passes 100.
  `LBCLG_ASSERT_HOLDS(a_level_range, level_r <= 4'd8)
  `LBCLG_ASSERT_HOLDS(a_floor_range, floor_r <= 4'd8)
  `LBCLG_ASSERT_HOLDS(a_load_range, load_r <= 7'd100)
  // The level moves only while an event is being worked on.
  `LBCLG_ASSERT_NEXT(a_idle_level_stable, state_r == FSM_IDLE, $stable(level_r))
  // A divider result arrives only while the controller waits for it.
  `LBCLG_ASSERT_NEXT(a_div_done_decide, div_rsp.done, state_r == FSM_DECIDE)

endmodule

FILE: hdl/lbclg_div.sv
// ---------------------------------------------------------------------------
// lbclg_div
// Bit-serial restoring divider for the load percentage busy*100/total.
// ---------------------------------------------------------------------------
module lbclg_div #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [COUNT_WIDTH-1:0]     busy_cnt,
  input  logic [COUNT_WIDTH:0]       total_cnt,
  output lbclg_pkg::div_rsp_t        rsp
);
  import lbclg_pkg::*;

  localparam int NW = COUNT_WIDTH + LOAD_W;

  logic [NW-1:0]        rem_r;
  logic [NW-1:0]        dvs_r;
  load_t                quot_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 run_r;
  logic                 done_r;
  logic [NW-1:0]        numer;
  logic                 ge;

  // busy * 100 as busy*64 + busy*32 + busy*4.
  assign numer = NW'({busy_cnt, 6'b0}) + NW'({busy_cnt, 5'b0}) + NW'({busy_cnt, 2'b0});
  assign ge    = (rem_r >= dvs_r);

  // Busy never exceeds the total, so the quotient fits in LOAD_W bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        cnt_r  <= DIV_CNT_W'(LOAD_W - 1);
        rem_r  <= numer;
        dvs_r  <= {total_cnt, (LOAD_W - 1)'(0)};
        quot_r <= '0;
      end else if (run_r) begin
        if (ge) begin
          rem_r <= rem_r - dvs_r;
        end
        quot_r <= {quot_r[LOAD_W-2:0], ge};
        dvs_r  <= dvs_r >> 1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule
